// ----- rtl/a64x_pkg.sv -----
// Shared types and constants for the A64 subset execute unit.
package a64x_pkg;

  typedef enum logic [3:0] {
    OP_ADDSUB_IMM,
    OP_ADDSUB_REG,
    OP_LOGIC,
    OP_MOVN,
    OP_MOVZ,
    OP_MOVK,
    OP_MADD,
    OP_B,
    OP_BCOND,
    OP_BR,
    OP_HALT,
    OP_UNSUP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] word;
  } dec_t;

  typedef struct packed {
    logic [31:0] instr_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  dest_index;
    logic [63:0] dest_value;
    logic [63:0] next_pc;
    logic [3:0]  flags_nzcv;
  } out_item_t;

  localparam logic [31:0] HALT_WORD   = 32'h8a00_0000;
  localparam logic [31:0] BR_MASK     = 32'hFFFF_FC1F;
  localparam logic [31:0] BR_PATTERN  = 32'hD61F_0000;
  localparam logic [5:0]  B_OPCODE    = 6'h05;
  localparam logic [7:0]  BCOND_OPCODE = 8'h54;

  localparam logic [1:0]  ST_EXEC  = 2'd0;
  localparam logic [1:0]  ST_HALT  = 2'd1;
  localparam logic [1:0]  ST_UNSUP = 2'd2;

  localparam logic [4:0]  REG_ZR      = 5'd31;
  localparam logic [3:0]  FLAGS_RESET = 4'b0100;
  localparam logic [63:0] HALF_MASK   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] HW_MASK     = 64'h0000_0000_0000_FFFF;

  localparam logic [3:0]  COND_EQ = 4'd0;
  localparam logic [3:0]  COND_NE = 4'd1;
  localparam logic [3:0]  COND_GE = 4'd10;
  localparam logic [3:0]  COND_LT = 4'd11;
  localparam logic [3:0]  COND_GT = 4'd12;
  localparam logic [3:0]  COND_LE = 4'd13;
  localparam logic [3:0]  COND_AL = 4'd14;

endpackage

// ----- rtl/a64x_stream_if.sv -----
// Valid/ready stream interface carrying one item of a given type.
interface a64x_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ----- rtl/a64x_subset_execute_unit.sv -----
// Top level of the A64 integer subset execute unit.
// One instruction item is accepted per cycle while the queue has room, and one
// result item is produced per instruction, in order. Every instruction but
// madd/msub passes through the back end without waiting, so the sustained rate is
// one item per cycle while the output is not stalled; madd/msub hold the back end
// while the shared 32x32 multiplier builds the 64-bit product from three partial
// products. An item enters the queue when it is accepted; when it is popped, its
// operands are read from the registered register file, and the result is then
// executed into the output register. Reset takes effect at once: per-register
// valid bits make all registers read zero, so there is no clearing pass.
module a64_subset_execute_unit #(
  parameter int NUM_REGS    = 31,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  a64x_stream_if.sink   in_ch,
  a64x_stream_if.source out_ch
);

  logic           q_ready, push, pop, head_valid;
  a64x_pkg::dec_t push_dec, head_dec;

  a64x_front u_front (
    .in_ch    (in_ch),
    .q_ready  (q_ready),
    .push     (push),
    .push_dec (push_dec)
  );

  a64x_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_dec   (push_dec),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_dec   (head_dec)
  );

  a64x_back #(.NUM_REGS(NUM_REGS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_dec   (head_dec),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ----- rtl/a64x_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module a64x_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

// ----- rtl/a64x_front.sv -----
// Front end: accepts instruction items and classifies them by operation.
module a64x_front (
  a64x_stream_if.sink      in_ch,
  input  logic             q_ready,
  output logic             push,
  output a64x_pkg::dec_t   push_dec
);

  assign in_ch.ready = q_ready;
  assign push        = in_ch.valid && q_ready;

  always_comb begin
    logic [31:0] w;
    w = in_ch.item.instr_word;
    push_dec.word = w;
    push_dec.op   = a64x_pkg::OP_UNSUP;
    if (w == a64x_pkg::HALT_WORD) begin
      push_dec.op = a64x_pkg::OP_HALT;
    end else if (w[28:26] == 3'b100) begin
      if (w[25:23] == 3'd2) begin
        push_dec.op = a64x_pkg::OP_ADDSUB_IMM;
      end else if (w[25:23] == 3'd5) begin
        if (w[30:29] == 2'd1 || (!w[31] && w[22])) begin
          push_dec.op = a64x_pkg::OP_UNSUP;
        end else begin
          case (w[30:29])
            2'd0:    push_dec.op = a64x_pkg::OP_MOVN;
            2'd2:    push_dec.op = a64x_pkg::OP_MOVZ;
            default: push_dec.op = a64x_pkg::OP_MOVK;
          endcase
        end
      end
    end else if (w[27:25] == 3'b101) begin
      if (!w[28] && w[24] && !w[21]) begin
        if (w[23:22] == 2'd3 || (!w[31] && w[15])) begin
          push_dec.op = a64x_pkg::OP_UNSUP;
        end else begin
          push_dec.op = a64x_pkg::OP_ADDSUB_REG;
        end
      end else if (!w[28] && !w[24]) begin
        if (!w[31] && w[15]) begin
          push_dec.op = a64x_pkg::OP_UNSUP;
        end else begin
          push_dec.op = a64x_pkg::OP_LOGIC;
        end
      end else if (w[28] && w[24:21] == 4'd8 && w[30:29] == 2'd0) begin
        push_dec.op = a64x_pkg::OP_MADD;
      end
    end else if (w[27] && !w[25]) begin
      push_dec.op = a64x_pkg::OP_UNSUP;
    end else if (w[28:26] == 3'b101) begin
      if (w[31:26] == a64x_pkg::B_OPCODE) begin
        push_dec.op = a64x_pkg::OP_B;
      end else if (w[31:24] == a64x_pkg::BCOND_OPCODE && !w[4]) begin
        push_dec.op = a64x_pkg::OP_BCOND;
      end else if ((w & a64x_pkg::BR_MASK) == a64x_pkg::BR_PATTERN) begin
        push_dec.op = a64x_pkg::OP_BR;
      end
    end
  end

endmodule

// ----- rtl/a64x_queue.sv -----
// Short FIFO of classified items between the front and back ends.
module a64x_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  a64x_pkg::dec_t push_dec,
  output logic           q_ready,
  input  logic           pop,
  output logic           head_valid,
  output a64x_pkg::dec_t head_dec
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  a64x_pkg::dec_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  assign q_ready    = cnt_r != CW'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_dec   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_dec;
    end
  end

endmodule

// ----- rtl/a64x_back.sv -----
// Back end: reads operands, executes, updates architectural state, drives results.
module a64x_back #(
  parameter int NUM_REGS = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  a64x_pkg::dec_t   head_dec,
  output logic             pop,
  a64x_stream_if.source    out_ch
);

  localparam int AW = $clog2(NUM_REGS);

  logic                  b_valid_r;
  a64x_pkg::dec_t        b_dec_r;
  logic [1:0]            mul_cnt_r;
  logic [63:0]           p0_r;
  logic [31:0]           p1_r, p2_r;
  logic [63:0]           pc_r;
  logic [3:0]            flags_r;
  logic                  halted_r;
  logic [NUM_REGS-1:0]   regv_r;
  logic                  fwd_valid_r;
  logic [4:0]            fwd_idx_r;
  logic [63:0]           fwd_val_r;
  logic                  out_valid_r;
  a64x_pkg::out_item_t   out_item_r;

  logic [63:0]  pc_nxt;
  logic [3:0]   flags_nxt;
  logic         halted_nxt;
  logic [1:0]   status;
  logic         do_write;
  logic [4:0]   dest;
  logic [63:0]  dval;

  logic         out_free, is_mul, fire;
  logic [31:0]  sel_word;
  logic [63:0]  ram_n, ram_m, ram_a, ram_d;
  logic [63:0]  vn, vm, va, vd;
  logic [31:0]  mul_x, mul_y;
  logic [63:0]  mul_p, prod;

  function automatic logic [63:0] rd_val(input logic [4:0] idx, input logic [63:0] ram_val,
                                         input logic [NUM_REGS-1:0] vbits, input logic fv,
                                         input logic [4:0] fi, input logic [63:0] fval);
    logic [63:0] r;
    if (idx == a64x_pkg::REG_ZR) begin
      r = '0;
    end else if (fv && fi == idx) begin
      r = fval;
    end else if (vbits[idx[AW-1:0]]) begin
      r = ram_val;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic logic [67:0] add_sub(input logic [63:0] a, input logic [63:0] b,
                                          input logic sub, input logic sf);
    logic [63:0] mask, am, bm, r, x;
    logic [64:0] s;
    logic        n, z, c, v;
    mask = sf ? '1 : a64x_pkg::HALF_MASK;
    am = a & mask;
    bm = b & mask;
    if (sub) begin
      bm = ~bm & mask;
    end
    s = {1'b0, am} + {1'b0, bm} + 65'(sub);
    r = s[63:0] & mask;
    c = sf ? s[64] : s[32];
    n = sf ? r[63] : r[31];
    z = r == '0;
    x = (am ^ r) & (bm ^ r);
    v = sf ? x[63] : x[31];
    return {n, z, c, v, r};
  endfunction

  function automatic logic [63:0] shift_op(input logic [63:0] val, input logic sf,
                                           input logic [1:0] kind, input logic [5:0] amt);
    logic [63:0]  mask, vv, r;
    logic [127:0] t64;
    logic [63:0]  t32;
    mask = sf ? '1 : a64x_pkg::HALF_MASK;
    vv   = val & mask;
    t64  = {vv, vv} >> amt;
    t32  = {vv[31:0], vv[31:0]} >> amt[4:0];
    case (kind)
      2'd0: r = (vv << amt) & mask;
      2'd1: r = vv >> amt;
      2'd2: begin
        if (sf) begin
          r = 64'($signed(vv) >>> amt);
        end else begin
          r = {32'b0, 32'($signed(vv[31:0]) >>> amt[4:0])};
        end
      end
      default: r = sf ? t64[63:0] : {32'b0, t32[31:0]};
    endcase
    return r;
  endfunction

  function automatic logic cond_ok(input logic [3:0] cond, input logic [3:0] f);
    logic n, z, v, r;
    n = f[3];
    z = f[2];
    v = f[0];
    case (cond)
      a64x_pkg::COND_EQ: r = z;
      a64x_pkg::COND_NE: r = !z;
      a64x_pkg::COND_GE: r = n == v;
      a64x_pkg::COND_LT: r = n != v;
      a64x_pkg::COND_GT: r = (n == v) && !z;
      a64x_pkg::COND_LE: r = !((n == v) && !z);
      a64x_pkg::COND_AL: r = 1'b1;
      default:           r = 1'b0;
    endcase
    return r;
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;
  assign is_mul   = b_dec_r.op == a64x_pkg::OP_MADD && !halted_r;
  assign fire     = b_valid_r && out_free && (!is_mul || mul_cnt_r == 2'd3);
  assign pop      = head_valid && (!b_valid_r || fire);
  assign sel_word = pop ? head_dec.word : b_dec_r.word;

  a64x_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_ram_nm (
    .clk     (clk),
    .we      (fire && do_write),
    .waddr   (dest[AW-1:0]),
    .wdata   (dval),
    .raddr_a (sel_word[5+AW-1:5]),
    .raddr_b (sel_word[16+AW-1:16]),
    .rdata_a (ram_n),
    .rdata_b (ram_m)
  );

  a64x_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_ram_ad (
    .clk     (clk),
    .we      (fire && do_write),
    .waddr   (dest[AW-1:0]),
    .wdata   (dval),
    .raddr_a (sel_word[10+AW-1:10]),
    .raddr_b (sel_word[AW-1:0]),
    .rdata_a (ram_a),
    .rdata_b (ram_d)
  );

  assign vn = rd_val(b_dec_r.word[9:5], ram_n, regv_r, fwd_valid_r, fwd_idx_r, fwd_val_r);
  assign vm = rd_val(b_dec_r.word[20:16], ram_m, regv_r, fwd_valid_r, fwd_idx_r, fwd_val_r);
  assign va = rd_val(b_dec_r.word[14:10], ram_a, regv_r, fwd_valid_r, fwd_idx_r, fwd_val_r);
  assign vd = rd_val(b_dec_r.word[4:0], ram_d, regv_r, fwd_valid_r, fwd_idx_r, fwd_val_r);

  assign mul_x = (mul_cnt_r == 2'd2) ? vn[63:32] : vn[31:0];
  assign mul_y = (mul_cnt_r == 2'd1) ? vm[63:32] : vm[31:0];
  assign mul_p = mul_x * mul_y;
  assign prod  = p0_r + {p1_r + p2_r, 32'b0};

  always_comb begin
    logic [31:0] w;
    logic        sf;
    logic [63:0] mask, imm, op2, res, a;
    logic [67:0] as;
    logic [5:0]  sh;
    logic        wr;
    w          = b_dec_r.word;
    sf         = w[31];
    mask       = sf ? '1 : a64x_pkg::HALF_MASK;
    sh         = {w[22:21], 4'b0};
    imm        = w[22] ? {40'b0, w[21:10], 12'b0} : {52'b0, w[21:10]};
    op2        = shift_op(vm, sf, w[23:22], w[15:10]);
    a          = vn & mask;
    as         = '0;
    res        = '0;
    wr         = 1'b0;
    status     = a64x_pkg::ST_EXEC;
    pc_nxt     = pc_r + 64'd4;
    flags_nxt  = flags_r;
    halted_nxt = halted_r;
    if (halted_r || b_dec_r.op == a64x_pkg::OP_HALT) begin
      halted_nxt = 1'b1;
      status     = a64x_pkg::ST_HALT;
      pc_nxt     = pc_r;
    end else begin
      case (b_dec_r.op)
        a64x_pkg::OP_ADDSUB_IMM, a64x_pkg::OP_ADDSUB_REG: begin
          as  = add_sub(vn, (b_dec_r.op == a64x_pkg::OP_ADDSUB_IMM) ? imm : op2, w[30], sf);
          res = as[63:0];
          if (w[29]) begin
            flags_nxt = as[67:64];
          end
          wr = 1'b1;
        end
        a64x_pkg::OP_LOGIC: begin
          if (w[21]) begin
            op2 = ~op2 & mask;
          end
          case (w[30:29])
            2'd1:    res = a | op2;
            2'd2:    res = a ^ op2;
            default: res = a & op2;
          endcase
          res = res & mask;
          if (w[30:29] == 2'd3) begin
            flags_nxt = {sf ? res[63] : res[31], res == '0, 2'b00};
          end
          wr = 1'b1;
        end
        a64x_pkg::OP_MOVN: begin
          res = ~({48'b0, w[20:5]} << sh) & mask;
          wr  = 1'b1;
        end
        a64x_pkg::OP_MOVZ: begin
          res = {48'b0, w[20:5]} << sh;
          wr  = 1'b1;
        end
        a64x_pkg::OP_MOVK: begin
          res = ((vd & ~(a64x_pkg::HW_MASK << sh)) | ({48'b0, w[20:5]} << sh)) & mask;
          wr  = 1'b1;
        end
        a64x_pkg::OP_MADD: begin
          res = (w[15] ? va - prod : va + prod) & mask;
          wr  = 1'b1;
        end
        a64x_pkg::OP_B: begin
          pc_nxt = pc_r + {{36{w[25]}}, w[25:0], 2'b00};
        end
        a64x_pkg::OP_BCOND: begin
          if (cond_ok(w[3:0], flags_r)) begin
            pc_nxt = pc_r + {{43{w[23]}}, w[23:5], 2'b00};
          end
        end
        a64x_pkg::OP_BR: begin
          pc_nxt = vn;
        end
        default: begin
          status = a64x_pkg::ST_UNSUP;
          pc_nxt = pc_r;
        end
      endcase
    end
    do_write = wr && w[4:0] != a64x_pkg::REG_ZR;
    dest     = do_write ? w[4:0] : a64x_pkg::REG_ZR;
    dval     = do_write ? res : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      mul_cnt_r   <= '0;
      pc_r        <= '0;
      flags_r     <= a64x_pkg::FLAGS_RESET;
      halted_r    <= 1'b0;
      regv_r      <= '0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        b_valid_r <= 1'b1;
      end else if (fire) begin
        b_valid_r <= 1'b0;
      end
      if (fire) begin
        mul_cnt_r <= '0;
      end else if (b_valid_r && is_mul && mul_cnt_r != 2'd3) begin
        mul_cnt_r <= mul_cnt_r + 1'b1;
      end
      if (fire) begin
        pc_r     <= pc_nxt;
        flags_r  <= flags_nxt;
        halted_r <= halted_nxt;
        if (do_write) begin
          regv_r[dest[AW-1:0]] <= 1'b1;
          fwd_valid_r          <= 1'b1;
        end
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_dec_r <= head_dec;
    end
    if (b_valid_r && is_mul) begin
      case (mul_cnt_r)
        2'd0:    p0_r <= mul_p;
        2'd1:    p1_r <= mul_p[31:0];
        2'd2:    p2_r <= mul_p[31:0];
        default: p0_r <= p0_r;
      endcase
    end
    if (fire && do_write) begin
      fwd_idx_r <= dest;
      fwd_val_r <= dval;
    end
    if (fire) begin
      out_item_r.status     <= status;
      out_item_r.dest_index <= dest;
      out_item_r.dest_value <= dval;
      out_item_r.next_pc    <= pc_nxt;
      out_item_r.flags_nzcv <= flags_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

endmodule

// ----- tb/tb_a64_subset_execute_unit.sv -----
// Self-checking testbench for the A64 subset execute unit, with a directed table and random instructions.
`timescale 1ns / 100ps
module tb_a64_subset_execute_unit;

  typedef struct {
    logic [31:0]         word;
    bit                  typed;
    a64x_pkg::out_item_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  a64x_stream_if #(.T(a64x_pkg::in_item_t))  in_ch();
  a64x_stream_if #(.T(a64x_pkg::out_item_t)) out_ch();

  a64_subset_execute_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic [63:0] arch_regs [31];
  logic [63:0] arch_pc;
  logic [3:0]  arch_nzcv;
  bit          arch_halted;

  a64x_pkg::out_item_t pending_results [$];
  int          n_errors;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  bit          hold_req;
  int          hold_left;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] read_reg(input logic [4:0] n);
    return (n == a64x_pkg::REG_ZR) ? 64'd0 : arch_regs[n];
  endfunction

  function automatic logic [63:0] add_with_flags(input logic [63:0] a, input logic [63:0] b,
                                                 input bit sub, input bit setf, input bit sf);
    logic [63:0] mask;
    logic [64:0] sum;
    logic [63:0] r;
    logic [63:0] x;
    logic        cy;
    int          top;
    mask = sf ? '1 : a64x_pkg::HALF_MASK;
    top  = sf ? 63 : 31;
    a = a & mask;
    b = b & mask;
    if (sub) b = ~b & mask;
    sum = {1'b0, a} + {1'b0, b} + 65'(sub);
    if (sf) begin
      r  = sum[63:0];
      cy = sum[64];
    end else begin
      r  = {32'd0, sum[31:0]};
      cy = sum[32];
    end
    if (setf) begin
      x = (a ^ r) & (b ^ r);
      arch_nzcv = {r[top], r == 64'd0, cy, x[top]};
    end
    return r;
  endfunction

  function automatic logic [63:0] shifted_operand(input logic [63:0] v, input bit sf,
                                                  input logic [1:0] kind, input int amt);
    logic [63:0] mask;
    int          width;
    mask  = sf ? '1 : a64x_pkg::HALF_MASK;
    width = sf ? 64 : 32;
    v = v & mask;
    case (kind)
      2'd0: return (v << amt) & mask;
      2'd1: return v >> amt;
      2'd2: begin
        if (v[width-1]) return ((v >> amt) | ~(mask >> amt)) & mask;
        return v >> amt;
      end
      default: begin
        if (amt == 0) return v;
        return ((v >> amt) | (v << (width - amt))) & mask;
      end
    endcase
  endfunction

  function automatic bit cond_passes(input logic [3:0] cc);
    bit n, z, v;
    n = arch_nzcv[3];
    z = arch_nzcv[2];
    v = arch_nzcv[0];
    case (cc)
      a64x_pkg::COND_EQ: return z;
      a64x_pkg::COND_NE: return !z;
      a64x_pkg::COND_GE: return n == v;
      a64x_pkg::COND_LT: return n != v;
      a64x_pkg::COND_GT: return (n == v) && !z;
      a64x_pkg::COND_LE: return !((n == v) && !z);
      a64x_pkg::COND_AL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic a64x_pkg::out_item_t execute_word(input logic [31:0] w);
    a64x_pkg::out_item_t r;
    bit          sf, ok, wr;
    logic [63:0] mask, res, npc, op2, a;
    logic [1:0]  st, opc;
    logic [4:0]  rd, rn, rm;
    logic [3:0]  opr;
    int          amt, sh;
    sf   = w[31];
    mask = sf ? '1 : a64x_pkg::HALF_MASK;
    rd   = w[4:0];
    rn   = w[9:5];
    rm   = w[20:16];
    opc  = w[30:29];
    st   = a64x_pkg::ST_EXEC;
    res  = 64'd0;
    npc  = arch_pc + 64'd4;
    ok   = 1'b1;
    wr   = 1'b0;
    if (arch_halted || w == a64x_pkg::HALT_WORD) begin
      arch_halted = 1'b1;
      st = a64x_pkg::ST_HALT;
      ok = 1'b0;
    end else if (w[28:26] == 3'b100) begin
      if (w[25:23] == 3'd2) begin
        op2 = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
        res = add_with_flags(read_reg(rn), op2, opc[1], opc[0], sf);
        wr  = 1'b1;
      end else if (w[25:23] == 3'd5) begin
        sh  = 16 * w[22:21];
        op2 = {48'd0, w[20:5]} << sh;
        if (opc == 2'd1 || (!sf && w[22])) ok = 1'b0;
        else if (opc == 2'd0) res = ~op2 & mask;
        else if (opc == 2'd2) res = op2;
        else res = ((read_reg(rd) & ~(a64x_pkg::HW_MASK << sh)) | op2) & mask;
        wr = ok;
      end else ok = 1'b0;
    end else if (w[27:25] == 3'b101) begin
      opr = w[24:21];
      amt = w[15:10];
      if (!w[28] && opr[3] && !opr[0]) begin
        if (w[23:22] == 2'd3 || (!sf && amt > 31)) ok = 1'b0;
        else begin
          op2 = shifted_operand(read_reg(rm), sf, w[23:22], amt);
          res = add_with_flags(read_reg(rn), op2, opc[1], opc[0], sf);
          wr  = 1'b1;
        end
      end else if (!w[28] && !opr[3]) begin
        if (!sf && amt > 31) ok = 1'b0;
        else begin
          op2 = shifted_operand(read_reg(rm), sf, w[23:22], amt);
          a   = read_reg(rn) & mask;
          if (opr[0]) op2 = ~op2 & mask;
          if (opc == 2'd1) res = a | op2;
          else if (opc == 2'd2) res = a ^ op2;
          else res = a & op2;
          res = res & mask;
          if (opc == 2'd3) arch_nzcv = {sf ? res[63] : res[31], res == 64'd0, 2'b00};
          wr = 1'b1;
        end
      end else if (w[28] && opr == 4'd8 && opc == 2'd0) begin
        op2 = read_reg(rn) * read_reg(rm);
        a   = read_reg(w[14:10]);
        res = (w[15] ? a - op2 : a + op2) & mask;
        wr  = 1'b1;
      end else ok = 1'b0;
    end else if (w[28:26] == 3'b101) begin
      if (w[31:26] == a64x_pkg::B_OPCODE) begin
        npc = arch_pc + {{36{w[25]}}, w[25:0], 2'b00};
      end else if (w[31:24] == a64x_pkg::BCOND_OPCODE && !w[4]) begin
        if (cond_passes(w[3:0])) npc = arch_pc + {{43{w[23]}}, w[23:5], 2'b00};
      end else if ((w & a64x_pkg::BR_MASK) == a64x_pkg::BR_PATTERN) begin
        npc = read_reg(rn);
      end else ok = 1'b0;
    end else ok = 1'b0;
    if (!ok) begin
      if (st == a64x_pkg::ST_EXEC) st = a64x_pkg::ST_UNSUP;
      wr  = 1'b0;
      res = 64'd0;
      npc = arch_pc;
    end
    if (wr && rd != a64x_pkg::REG_ZR) arch_regs[rd] = res;
    else begin
      rd  = a64x_pkg::REG_ZR;
      res = 64'd0;
    end
    arch_pc = npc;
    r.status     = st;
    r.dest_index = rd;
    r.dest_value = res;
    r.next_pc    = arch_pc;
    r.flags_nzcv = arch_nzcv;
    return r;
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    bit          sf;
    sf = $urandom_range(0, 1);
    case ($urandom_range(0, 10))
      0: w = {sf, 2'($urandom), 6'b100010, 1'($urandom), 12'($urandom), 10'($urandom)};
      1: w = {sf, 2'($urandom), 5'b01011, 2'($urandom_range(0, 2)),
              ($urandom_range(0, 9) == 0) ? 1'b1 : 1'b0, 5'($urandom),
              6'($urandom_range(0, sf ? 63 : 31)), 10'($urandom)};
      2, 3: w = {sf, 2'($urandom), 5'b01010, 3'($urandom), 5'($urandom),
                 6'($urandom_range(0, sf ? 63 : 31)), 10'($urandom)};
      4: w = {sf, 2'($urandom), 6'b100101, 1'(sf ? $urandom : 0), 1'($urandom),
              21'($urandom)};
      5: w = {sf, 2'b00, 5'b11011, 3'b000, 16'($urandom), 5'($urandom)};
      6: w = {a64x_pkg::B_OPCODE, 26'($urandom)};
      7: w = {a64x_pkg::BCOND_OPCODE, 19'($urandom), 1'b0, 4'($urandom)};
      8: w = {a64x_pkg::BR_PATTERN[31:10], 5'($urandom), 5'b00000};
      default: w = $urandom;
    endcase
    if (w == a64x_pkg::HALT_WORD) w = 32'd0;
    return w;
  endfunction

  task automatic offer_item(input logic [31:0] w, input bit typed,
                            input a64x_pkg::out_item_t typed_res);
    a64x_pkg::out_item_t r;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    in_ch.valid           <= 1'b1;
    in_ch.item.instr_word <= w;
    do @(posedge clk); while (!in_ch.ready);
    r = execute_word(w);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  always @(posedge clk) begin
    a64x_pkg::out_item_t e, g;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 3000) begin
        $display("end of test: mismatches");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        g = out_ch.item;
        if (pending_results.size() == 0) begin
          n_errors <= n_errors + 1;
          $display("%0t: unexpected result %p", $time, g);
        end else begin
          e = pending_results.pop_front();
          if (g.status !== e.status || g.dest_index !== e.dest_index ||
              g.dest_value !== e.dest_value || g.next_pc !== e.next_pc ||
              g.flags_nzcv !== e.flags_nzcv) begin
            n_errors <= n_errors + 1;
            $display("%0t: expected %p, actual %p", $time, e, g);
          end
        end
      end
      if (hold_req) begin
        hold_req  <= 1'b0;
        hold_left <= 60;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    a64x_pkg::out_item_t none;
    int        k;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.item.instr_word = 32'd0;
    out_ch.ready          = 1'b0;
    n_errors     = 0;
    hold_req     = 1'b0;
    hold_left    = 0;
    quiet_cycles = 0;
    arch_pc      = 64'd0;
    arch_nzcv    = a64x_pkg::FLAGS_RESET;
    arch_halted  = 1'b0;
    foreach (arch_regs[i]) arch_regs[i] = 64'd0;
    none = '0;
    snd_idle_pct = 33;
    rcv_idle_pct = 56;
    rows = '{
      '{32'hF940_0020, 1'b1, '{a64x_pkg::ST_UNSUP, a64x_pkg::REG_ZR, 64'd0, 64'd0,
                               a64x_pkg::FLAGS_RESET}},
      '{32'hD2FF_FFE1, 1'b0, none}, '{32'h1280_0002, 1'b0, none},
      '{32'hF282_4681, 1'b0, none}, '{32'h913F_FC23, 1'b0, none},
      '{32'h3100_0444, 1'b0, none}, '{32'hEB01_0025, 1'b0, none},
      '{32'h8BC1_0020, 1'b0, none}, '{32'h0B01_8020, 1'b0, none},
      '{32'h8A01_0020, 1'b0, none}, '{32'hAA21_03E6, 1'b0, none},
      '{32'hCA41_0427, 1'b0, none}, '{32'hEA61_0028, 1'b0, none},
      '{32'h9B02_0C29, 1'b0, none}, '{32'h9B02_8C2A, 1'b0, none},
      '{32'h5400_0040, 1'b0, none}, '{32'h5400_004F, 1'b0, none},
      '{32'h5400_0041, 1'b0, none}, '{32'h1400_0004, 1'b0, none},
      '{32'h17FF_FFFF, 1'b0, none}, '{32'h3280_0000, 1'b0, none},
      '{32'h52C0_0000, 1'b0, none}, '{32'hBB00_0000, 1'b0, none},
      '{32'hB100_041F, 1'b0, none}, '{32'hD61F_0060, 1'b0, none},
      '{32'hD61F_03E0, 1'b0, none}, '{32'hFFFF_FFFF, 1'b0, none},
      '{32'h0000_0000, 1'b0, none}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) offer_item(rows[i].word, rows[i].typed, rows[i].res);
    hold_req <= 1'b1;
    for (k = 0; k < 1230; k++) begin
      if (k == 410) begin
        snd_idle_pct = 56;
        rcv_idle_pct = 33;
      end
      if (k == 820) begin
        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      offer_item(random_word(), 1'b0, none);
    end
    offer_item(a64x_pkg::HALT_WORD, 1'b0, none);
    repeat (6) offer_item($urandom, 1'b0, none);
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk);
    if (n_errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/a64x_pkg.sv
rtl/a64x_stream_if.sv
rtl/a64x_ram.sv
rtl/a64x_front.sv
rtl/a64x_queue.sv
rtl/a64x_back.sv
rtl/a64x_subset_execute_unit.sv
tb/tb_a64_subset_execute_unit.sv
